// ----- sv/tpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

   // angle input width, 65536 = one turn at 16 bits
   localparam int ANGLE_BITS = 16;

   // pi/2 in Q30
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   localparam int TERMS    = 7;     // series steps per function
   localparam int X_W      = 29;    // angle in radians, Q1.28, non-negative
   localparam int X2_W     = 30;    // x squared, Q28
   localparam int TERM_W   = 31;    // series term, non-negative
   localparam int SUM_W    = 32;    // signed partial sum
   localparam int TRIG_W   = 30;    // signed sin/cos, Q28
   localparam int TRIG_ONE = 268435456;
   localparam int DIV_W    = 8;

   localparam int R_W      = 34;    // ring, rs, rc: signed Q18.16
   localparam int VEC_W    = 36;    // one vector component before rotation
   localparam int PROD_W   = 64;    // Q18.16 times Q28
   localparam int ROT_W    = 52;    // Q2.14 entry times vector component
   localparam int ACC_W    = 40;    // rounded row sum, Q24.16

   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = 5;
   localparam int CNT_W      = 6;

   // series divisors (2k)(2k+1) and (2k-1)(2k)
   localparam logic [DIV_W-1:0] SIN_DIV [TERMS] = '{
      8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
   localparam logic [DIV_W-1:0] COS_DIV [TERMS] = '{
      8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

   // floor(2^32 / d), quotient estimate low by at most one
   localparam logic [31:0] SIN_RECIP [TERMS] = '{
      32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
      32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
      32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156),
      32'((64'd1 << 32) / 64'd210)};
   localparam logic [31:0] COS_RECIP [TERMS] = '{
      32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
      32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
      32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
      32'((64'd1 << 32) / 64'd182)};

   // vector kinds
   localparam logic [2:0] KIND_POINT    = 3'd0;
   localparam logic [2:0] KIND_GRAD_U   = 3'd1;
   localparam logic [2:0] KIND_GRAD_V   = 3'd2;
   localparam logic [2:0] KIND_SECOND_U = 3'd3;
   localparam logic [2:0] KIND_SECOND_V = 3'd4;
   localparam logic [2:0] KIND_MIXED    = 3'd5;

   // derivative orders
   localparam logic [1:0] ORDER_POINT = 2'd0;
   localparam logic [1:0] ORDER_GRAD  = 2'd1;

   // register indexes
   localparam logic [2:0] REG_MAJOR    = 3'd0;
   localparam logic [2:0] REG_MINOR    = 3'd1;
   localparam logic [2:0] REG_ROW_X    = 3'd2;
   localparam logic [2:0] REG_ROW_Y    = 3'd3;
   localparam logic [2:0] REG_ROW_Z    = 3'd4;
   localparam logic [2:0] REG_OFFSET_X = 3'd5;
   localparam logic [2:0] REG_OFFSET_Y = 3'd6;
   localparam logic [2:0] REG_OFFSET_Z = 3'd7;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle_u;
      logic [ANGLE_BITS-1:0] angle_v;
      logic [1:0]            derivative_order;
   } tpd_req_type;

   typedef struct packed {
      logic [2:0]         vector_kind;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic               last_of_run;
   } tpd_rsp_type;

   // one lane of the series pipeline
   typedef struct packed {
      logic [1:0]              quad;
      logic [X2_W-1:0]         x2;
      logic [TERM_W-1:0]       ts;
      logic [TERM_W-1:0]       tc;
      logic [TERM_W-1:0]       ps;
      logic [TERM_W-1:0]       pc;
      logic signed [SUM_W-1:0] ss;
      logic signed [SUM_W-1:0] sc;
   } tpd_lane_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] su;
      logic signed [TRIG_W-1:0] cu;
      logic signed [TRIG_W-1:0] sv;
      logic signed [TRIG_W-1:0] cv;
      logic [1:0]               order;
   } tpd_trig_type;

   // per-item data between the front pipeline and the vector sequencer
   typedef struct packed {
      logic signed [R_W-1:0]    ring;
      logic signed [R_W-1:0]    rs;
      logic signed [R_W-1:0]    rc;
      logic signed [TRIG_W-1:0] su;
      logic signed [TRIG_W-1:0] cu;
      logic [1:0]               order;
   } tpd_entry_type;

endpackage

`default_nettype wire

// ----- sv/tpd_trig.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined sine/cosine of both angles; three stages per series step.
module tpd_trig (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [tpd_pkg::ANGLE_BITS-1:0]  angle_u,
   input  logic [tpd_pkg::ANGLE_BITS-1:0]  angle_v,
   input  logic [1:0]                      order_in,
   output logic                            out_valid,
   output tpd_pkg::tpd_trig_type           out_data
);

   localparam int NST = 3 * tpd_pkg::TERMS;
   localparam int LAT = NST + 3;

   logic [LAT-1:0] vld_ff;
   logic [1:0]     ord_ff [LAT];

   logic signed [tpd_pkg::TRIG_W-1:0] sin_ff [2];
   logic signed [tpd_pkg::TRIG_W-1:0] cos_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      ord_ff[0] <= order_in;
      for (int i = 1; i < LAT; i++) begin
         ord_ff[i] <= ord_ff[i-1];
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_lane
      logic [tpd_pkg::ANGLE_BITS-1:0] angle;
      logic [31:0]                    phase;
      logic [60:0]                    xprod;
      logic [57:0]                    xsq;
      logic [tpd_pkg::X_W-1:0]        x_ff;
      logic [1:0]                     quad_ff;
      tpd_pkg::tpd_lane_type          st_ff [NST+1];
      logic signed [tpd_pkg::TRIG_W-1:0] cs_s;
      logic signed [tpd_pkg::TRIG_W-1:0] cs_c;

      if (g == 0) begin : g_u
         assign angle = angle_u;
      end else begin : g_v
         assign angle = angle_v;
      end

      assign phase = 32'(angle) << (32 - tpd_pkg::ANGLE_BITS);
      assign xprod = 61'(phase[29:0]) * 61'(tpd_pkg::HALF_PI_Q30);
      assign xsq   = 58'(x_ff) * 58'(x_ff);

      // radians in Q1.28
      always_ff @(posedge clock) begin
         x_ff    <= xprod[60:32];
         quad_ff <= phase[31:30];
      end

      // series seed
      always_ff @(posedge clock) begin
         st_ff[0].quad <= quad_ff;
         st_ff[0].x2   <= xsq[57:28];
         st_ff[0].ts   <= tpd_pkg::TERM_W'(x_ff);
         st_ff[0].tc   <= tpd_pkg::TERM_W'(tpd_pkg::TRIG_ONE);
         st_ff[0].ps   <= '0;
         st_ff[0].pc   <= '0;
         st_ff[0].ss   <= tpd_pkg::SUM_W'(x_ff);
         st_ff[0].sc   <= tpd_pkg::SUM_W'(tpd_pkg::TRIG_ONE);
      end

      for (genvar j = 0; j < tpd_pkg::TERMS; j++) begin : g_step
         logic [60:0]                 ms;
         logic [60:0]                 mc;
         logic [62:0]                 es;
         logic [62:0]                 ec;
         logic [38:0]                 ds;
         logic [38:0]                 dc;
         logic [tpd_pkg::TERM_W-1:0]  rem_s;
         logic [tpd_pkg::TERM_W-1:0]  rem_c;
         logic [tpd_pkg::TERM_W-1:0]  q_s;
         logic [tpd_pkg::TERM_W-1:0]  q_c;
         tpd_pkg::tpd_lane_type       s1_in;
         tpd_pkg::tpd_lane_type       s2_in;
         tpd_pkg::tpd_lane_type       s3_in;

         // term times x^2
         assign ms = 61'(st_ff[3*j].ts) * 61'(st_ff[3*j].x2);
         assign mc = 61'(st_ff[3*j].tc) * 61'(st_ff[3*j].x2);

         always_comb begin
            s1_in    = st_ff[3*j];
            s1_in.ps = ms[58:28];
            s1_in.pc = mc[58:28];
         end

         always_ff @(posedge clock) begin
            st_ff[3*j+1] <= s1_in;
         end

         // quotient estimate by reciprocal
         assign es = 63'(st_ff[3*j+1].ps) * 63'(tpd_pkg::SIN_RECIP[j]);
         assign ec = 63'(st_ff[3*j+1].pc) * 63'(tpd_pkg::COS_RECIP[j]);

         always_comb begin
            s2_in    = st_ff[3*j+1];
            s2_in.ts = es[62:32];
            s2_in.tc = ec[62:32];
         end

         always_ff @(posedge clock) begin
            st_ff[3*j+2] <= s2_in;
         end

         // fix estimate, then accumulate with alternating sign
         assign ds    = 39'(st_ff[3*j+2].ts) * 39'(tpd_pkg::SIN_DIV[j]);
         assign dc    = 39'(st_ff[3*j+2].tc) * 39'(tpd_pkg::COS_DIV[j]);
         assign rem_s = st_ff[3*j+2].ps - ds[tpd_pkg::TERM_W-1:0];
         assign rem_c = st_ff[3*j+2].pc - dc[tpd_pkg::TERM_W-1:0];
         assign q_s   = st_ff[3*j+2].ts + tpd_pkg::TERM_W'(
                           rem_s >= tpd_pkg::TERM_W'(tpd_pkg::SIN_DIV[j]));
         assign q_c   = st_ff[3*j+2].tc + tpd_pkg::TERM_W'(
                           rem_c >= tpd_pkg::TERM_W'(tpd_pkg::COS_DIV[j]));

         always_comb begin
            s3_in    = st_ff[3*j+2];
            s3_in.ts = q_s;
            s3_in.tc = q_c;
            if ((j % 2) == 0) begin
               s3_in.ss = st_ff[3*j+2].ss - tpd_pkg::SUM_W'(q_s);
               s3_in.sc = st_ff[3*j+2].sc - tpd_pkg::SUM_W'(q_c);
            end else begin
               s3_in.ss = st_ff[3*j+2].ss + tpd_pkg::SUM_W'(q_s);
               s3_in.sc = st_ff[3*j+2].sc + tpd_pkg::SUM_W'(q_c);
            end
         end

         always_ff @(posedge clock) begin
            st_ff[3*j+3] <= s3_in;
         end
      end

      // clamp to [0, 1.0]
      always_comb begin
         if (st_ff[NST].ss < 0) begin
            cs_s = '0;
         end else if (st_ff[NST].ss > tpd_pkg::TRIG_ONE) begin
            cs_s = tpd_pkg::TRIG_W'(tpd_pkg::TRIG_ONE);
         end else begin
            cs_s = st_ff[NST].ss[tpd_pkg::TRIG_W-1:0];
         end
         if (st_ff[NST].sc < 0) begin
            cs_c = '0;
         end else if (st_ff[NST].sc > tpd_pkg::TRIG_ONE) begin
            cs_c = tpd_pkg::TRIG_W'(tpd_pkg::TRIG_ONE);
         end else begin
            cs_c = st_ff[NST].sc[tpd_pkg::TRIG_W-1:0];
         end
      end

      // quadrant placement
      always_ff @(posedge clock) begin
         case (st_ff[NST].quad)
            2'd0: begin
               sin_ff[g] <= cs_s;
               cos_ff[g] <= cs_c;
            end
            2'd1: begin
               sin_ff[g] <= cs_c;
               cos_ff[g] <= -cs_s;
            end
            2'd2: begin
               sin_ff[g] <= -cs_s;
               cos_ff[g] <= -cs_c;
            end
            default: begin
               sin_ff[g] <= -cs_c;
               cos_ff[g] <= cs_s;
            end
         endcase
      end
   end

   assign out_valid      = vld_ff[LAT-1];
   assign out_data.su    = sin_ff[0];
   assign out_data.cu    = cos_ff[0];
   assign out_data.sv    = sin_ff[1];
   assign out_data.cv    = cos_ff[1];
   assign out_data.order = ord_ff[LAT-1];

endmodule

`default_nettype wire

// ----- sv/torus_point_and_derivatives_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                     Beat taken when
// -------   ---------------------------------------   ---------------------
// request   start, busy, req_data                     start && !busy
// response  rsp_strobe, rsp_data                      rsp_strobe (no stall)
// csr       csr_we, csr_index, csr_wdata              csr_we
//
// An item passes through the sin/cos series pipeline and the tube radius
// terms, then waits in a 32-entry queue. A sequencer emits 1, 3 or 6
// vectors (order 0, 1, or 2 and 3) at one per cycle through a 5-stage
// rotate/round/saturate pipeline. Sustained rate is set by the sequencer,
// which takes the next item while it emits the last vector of an item.
// busy rises when 32 items are held between start and the sequencer.
// Synchronous reset restores register defaults and empties all pipelines.
module torus_point_and_derivatives_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tpd_pkg::tpd_req_type req_data,
   output logic                 rsp_strobe,
   output tpd_pkg::tpd_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [47:0]          csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [31:0]        major_ff;
   logic [31:0]        minor_ff;
   logic [47:0]        row_ff [3];
   logic signed [31:0] offset_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff     <= 32'd65536;
         minor_ff     <= 32'd32768;
         row_ff[0]    <= 48'd16384;
         row_ff[1]    <= 48'd16384 << 16;
         row_ff[2]    <= 48'd16384 << 32;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tpd_pkg::REG_MAJOR:    major_ff     <= csr_wdata[31:0];
            tpd_pkg::REG_MINOR:    minor_ff     <= csr_wdata[31:0];
            tpd_pkg::REG_ROW_X:    row_ff[0]    <= csr_wdata;
            tpd_pkg::REG_ROW_Y:    row_ff[1]    <= csr_wdata;
            tpd_pkg::REG_ROW_Z:    row_ff[2]    <= csr_wdata;
            tpd_pkg::REG_OFFSET_X: offset_ff[0] <= csr_wdata[31:0];
            tpd_pkg::REG_OFFSET_Y: offset_ff[1] <= csr_wdata[31:0];
            tpd_pkg::REG_OFFSET_Z: offset_ff[2] <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // ---------------- admission ----------------
   // credits count items past start that the sequencer has not yet taken,
   // so the queue can never overflow.
   logic                      accept;
   logic                      pop;
   logic [tpd_pkg::CNT_W-1:0] credit_ff, credit_in;

   assign accept = start && !busy;
   assign busy   = (credit_ff == tpd_pkg::CNT_W'(tpd_pkg::FIFO_DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if (accept && !pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (!accept && pop) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // ---------------- sin / cos ----------------
   logic                  trig_vld;
   tpd_pkg::tpd_trig_type trig;

   tpd_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle_u   (req_data.angle_u),
      .angle_v   (req_data.angle_v),
      .order_in  (req_data.derivative_order),
      .out_valid (trig_vld),
      .out_data  (trig)
   );

   // ---------------- tube terms: r cos v, r sin v ----------------
   logic signed [32:0]                 minor_s;
   logic signed [62:0]                 rc_prod, rs_prod;
   logic signed [62:0]                 rc_prod_ff, rs_prod_ff;
   logic [31:0]                        major_d_ff;
   logic signed [tpd_pkg::TRIG_W-1:0]  su_d_ff, cu_d_ff;
   logic [1:0]                         order_d_ff;
   logic                               tube_vld_ff;

   assign minor_s = {1'b0, minor_ff};
   assign rc_prod = minor_s * trig.cv;
   assign rs_prod = minor_s * trig.sv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tube_vld_ff <= 1'b0;
      end else begin
         tube_vld_ff <= trig_vld;
      end
   end

   always_ff @(posedge clock) begin
      rc_prod_ff <= rc_prod;
      rs_prod_ff <= rs_prod;
      major_d_ff <= major_ff;
      su_d_ff    <= trig.su;
      cu_d_ff    <= trig.cu;
      order_d_ff <= trig.order;
   end

   // round to nearest, ties up, Q44 -> Q16
   logic signed [62:0]              rc_rnd, rs_rnd;
   logic signed [tpd_pkg::R_W-1:0]  rc_q, rs_q;
   tpd_pkg::tpd_entry_type          entry_ff;
   logic                            entry_vld_ff;

   assign rc_rnd = rc_prod_ff + 63'sd134217728;
   assign rs_rnd = rs_prod_ff + 63'sd134217728;
   assign rc_q   = rc_rnd[61:28];
   assign rs_q   = rs_rnd[61:28];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= 1'b0;
      end else begin
         entry_vld_ff <= tube_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.ring  <= tpd_pkg::R_W'(major_d_ff) + rc_q;
      entry_ff.rs    <= rs_q;
      entry_ff.rc    <= rc_q;
      entry_ff.su    <= su_d_ff;
      entry_ff.cu    <= cu_d_ff;
      entry_ff.order <= order_d_ff;
   end

   // ---------------- item queue ----------------
   tpd_pkg::tpd_entry_type    fifo_mem [tpd_pkg::FIFO_DEPTH];
   logic [tpd_pkg::PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tpd_pkg::CNT_W-1:0] fifo_cnt_ff;

   always_ff @(posedge clock) begin
      if (entry_vld_ff) begin
         fifo_mem[wr_ptr_ff] <= entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (entry_vld_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (entry_vld_ff && !pop) begin
            fifo_cnt_ff <= fifo_cnt_ff + 1'b1;
         end else if (!entry_vld_ff && pop) begin
            fifo_cnt_ff <= fifo_cnt_ff - 1'b1;
         end
      end
   end

   // ---------------- vector sequencer ----------------
   tpd_pkg::tpd_entry_type cur_ff;
   logic                   cur_vld_ff;
   logic [2:0]             kind_ff;
   logic [2:0]             last_ff;
   logic                   at_last;
   logic [2:0]             last_in;

   assign at_last = (kind_ff == last_ff);
   assign pop     = (fifo_cnt_ff != '0) && (!cur_vld_ff || at_last);

   always_comb begin
      unique case (fifo_mem[rd_ptr_ff].order)
         tpd_pkg::ORDER_POINT: last_in = tpd_pkg::KIND_POINT;
         tpd_pkg::ORDER_GRAD:  last_in = tpd_pkg::KIND_GRAD_V;
         default:              last_in = tpd_pkg::KIND_MIXED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         kind_ff    <= tpd_pkg::KIND_POINT;
      end else if (pop) begin
         cur_vld_ff <= 1'b1;
         kind_ff    <= tpd_pkg::KIND_POINT;
      end else if (cur_vld_ff) begin
         cur_vld_ff <= !at_last;
         kind_ff    <= kind_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff  <= fifo_mem[rd_ptr_ff];
         last_ff <= last_in;
      end
   end

   // ---------------- V1: pick factors and multiply ----------------
   logic signed [tpd_pkg::R_W-1:0]    ax, ay;
   logic signed [tpd_pkg::TRIG_W-1:0] bx, by;
   logic                              nx, ny;
   logic signed [tpd_pkg::VEC_W-1:0]  zsel;
   logic signed [tpd_pkg::VEC_W-1:0]  rs_w, rc_w;

   assign rs_w = tpd_pkg::VEC_W'(cur_ff.rs);
   assign rc_w = tpd_pkg::VEC_W'(cur_ff.rc);

   always_comb begin
      unique case (kind_ff)
         tpd_pkg::KIND_POINT: begin
            ax = cur_ff.ring; bx = cur_ff.cu; nx = 1'b0;
            ay = cur_ff.ring; by = cur_ff.su; ny = 1'b0;
            zsel = rs_w;
         end
         tpd_pkg::KIND_GRAD_U: begin
            ax = cur_ff.ring; bx = cur_ff.su; nx = 1'b1;
            ay = cur_ff.ring; by = cur_ff.cu; ny = 1'b0;
            zsel = '0;
         end
         tpd_pkg::KIND_GRAD_V: begin
            ax = cur_ff.rs; bx = cur_ff.cu; nx = 1'b1;
            ay = cur_ff.rs; by = cur_ff.su; ny = 1'b1;
            zsel = rc_w;
         end
         tpd_pkg::KIND_SECOND_U: begin
            ax = cur_ff.ring; bx = cur_ff.cu; nx = 1'b1;
            ay = cur_ff.ring; by = cur_ff.su; ny = 1'b1;
            zsel = '0;
         end
         tpd_pkg::KIND_SECOND_V: begin
            ax = cur_ff.rc; bx = cur_ff.cu; nx = 1'b1;
            ay = cur_ff.rc; by = cur_ff.su; ny = 1'b1;
            zsel = -rs_w;
         end
         default: begin
            ax = cur_ff.rs; bx = cur_ff.su; nx = 1'b0;
            ay = cur_ff.rs; by = cur_ff.cu; ny = 1'b1;
            zsel = '0;
         end
      endcase
   end

   logic signed [tpd_pkg::PROD_W-1:0] px_ff, py_ff;
   logic signed [tpd_pkg::VEC_W-1:0]  z1_ff;
   logic                              nx_ff, ny_ff;
   logic [2:0]                        k1_ff;
   logic                              l1_ff;
   logic                              v1_ff;

   always_ff @(posedge clock) begin
      px_ff <= ax * bx;
      py_ff <= ay * by;
      z1_ff <= zsel;
      nx_ff <= nx;
      ny_ff <= ny;
      k1_ff <= kind_ff;
      l1_ff <= at_last;
   end

   // ---------------- V2: round and negate ----------------
   logic signed [tpd_pkg::PROD_W-1:0] px_rnd, py_rnd;
   logic signed [tpd_pkg::VEC_W-1:0]  rx, ry;
   logic signed [tpd_pkg::VEC_W-1:0]  vec_ff [3];
   logic [2:0]                        k2_ff;
   logic                              l2_ff;
   logic                              v2_ff;

   assign px_rnd = px_ff + 64'sd134217728;
   assign py_rnd = py_ff + 64'sd134217728;
   assign rx     = px_rnd[63:28];
   assign ry     = py_rnd[63:28];

   always_ff @(posedge clock) begin
      vec_ff[0] <= nx_ff ? -rx : rx;
      vec_ff[1] <= ny_ff ? -ry : ry;
      vec_ff[2] <= z1_ff;
      k2_ff     <= k1_ff;
      l2_ff     <= l1_ff;
   end

   // ---------------- V3: rotation products ----------------
   logic signed [15:0]               ment [3][3];
   logic signed [tpd_pkg::ROT_W-1:0] rot_ff [3][3];
   logic [2:0]                       k3_ff;
   logic                             l3_ff;
   logic                             v3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            ment[i][c] = row_ff[i][16*c +: 16];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            rot_ff[i][c] <= ment[i][c] * vec_ff[c];
         end
      end
      k3_ff <= k2_ff;
      l3_ff <= l2_ff;
   end

   // ---------------- V4: row sums, round Q30 -> Q16 ----------------
   logic signed [53:0]                rsum [3];
   logic signed [tpd_pkg::ACC_W-1:0]  acc_ff [3];
   logic [2:0]                        k4_ff;
   logic                              l4_ff;
   logic                              v4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsum[i] = 54'(rot_ff[i][0]) + 54'(rot_ff[i][1]) + 54'(rot_ff[i][2])
                 + 54'sd8192;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         acc_ff[i] <= rsum[i][53:14];
      end
      k4_ff <= k3_ff;
      l4_ff <= l3_ff;
   end

   // ---------------- V5: offset on the point, saturate ----------------
   logic signed [40:0] fin [3];
   logic signed [31:0] sat [3];
   logic               strobe_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin[i] = 41'(acc_ff[i]);
         if (k4_ff == tpd_pkg::KIND_POINT) begin
            fin[i] = 41'(acc_ff[i]) + 41'(offset_ff[i]);
         end
         if (fin[i] > 41'sd2147483647) begin
            sat[i] = 32'sh7FFFFFFF;
         end else if (fin[i] < -41'sd2147483648) begin
            sat[i] = 32'sh80000000;
         end else begin
            sat[i] = fin[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data.vector_kind <= k4_ff;
      rsp_data.coord_x     <= sat[0];
      rsp_data.coord_y     <= sat[1];
      rsp_data.coord_z     <= sat[2];
      rsp_data.last_of_run <= l4_ff;
   end

   // valid bits of the vector pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= cur_vld_ff;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         strobe_ff <= v4_ff;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// ----- tb/tb_torus_point_and_derivatives_unit.sv -----
`timescale 1ns / 1ps

module tb_torus_point_and_derivatives_unit;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 60;    // extra wait at the end of each drain

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   tpd_pkg::tpd_req_type req_data;
   logic                 rsp_strobe;
   tpd_pkg::tpd_rsp_type rsp_data;
   logic                 csr_we;
   logic [2:0]           csr_index;
   logic [47:0]          csr_wdata;

   torus_point_and_derivatives_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // shadow copy of the register file
   longint unsigned radius_major, radius_minor;
   logic [47:0]     rot_row [3];
   longint          shift_xyz [3];

   tpd_pkg::tpd_req_type pending_items [$];   // beats still to drive
   tpd_pkg::tpd_rsp_type expected_vectors [$];
   bit          gaps_on;
   int          idle_left;
   int          mismatches;
   int          cycles;

   // round half up, arithmetic shift
   function automatic longint round_shift(input longint val, input int n);
      return (val + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint trig_scale(input longint q16, input longint trig);
      return round_shift(q16 * trig, 28);
   endfunction

   // Q28 sine/cosine from a turn fraction, series through x^15 / x^14
   function automatic void sin_cos_q28(input logic [tpd_pkg::ANGLE_BITS-1:0] ang,
                                       output longint s, output longint c);
      logic [31:0] phase;
      longint frac, x, x2, ts, tc, ss, sc;
      phase = 32'(ang) << (32 - tpd_pkg::ANGLE_BITS);
      frac = longint'(phase[29:0]);
      x = (frac * 64'sd1686629713) >>> 32;
      x2 = (x * x) >>> 28;
      ts = x; ss = x; tc = tpd_pkg::TRIG_ONE; sc = tpd_pkg::TRIG_ONE;
      for (int k = 1; k <= 7; k++) begin
         ts = ((ts * x2) >>> 28) / ((2 * k) * (2 * k + 1));
         tc = ((tc * x2) >>> 28) / ((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            ss -= ts; sc -= tc;
         end else begin
            ss += ts; sc += tc;
         end
      end
      if (ss < 0) ss = 0;
      if (ss > tpd_pkg::TRIG_ONE) ss = tpd_pkg::TRIG_ONE;
      if (sc < 0) sc = 0;
      if (sc > tpd_pkg::TRIG_ONE) sc = tpd_pkg::TRIG_ONE;
      case (phase[31:30])
         2'd0: begin s = ss; c = sc; end
         2'd1: begin s = sc; c = -ss; end
         2'd2: begin s = -ss; c = -sc; end
         default: begin s = -sc; c = ss; end
      endcase
   endfunction

   // expand one request into its rotated, offset and saturated vectors
   task automatic queue_torus_vectors(input tpd_pkg::tpd_req_type item);
      longint su, cu, sv, cv, rc, rs, ring, acc, r;
      longint vec [6][3];
      logic [2:0] kinds [6];
      int count;
      tpd_pkg::tpd_rsp_type exp_vec;
      kinds = '{tpd_pkg::KIND_POINT, tpd_pkg::KIND_GRAD_U, tpd_pkg::KIND_GRAD_V,
                tpd_pkg::KIND_SECOND_U, tpd_pkg::KIND_SECOND_V, tpd_pkg::KIND_MIXED};
      sin_cos_q28(item.angle_u, su, cu);
      sin_cos_q28(item.angle_v, sv, cv);
      rc = trig_scale(longint'(radius_minor), cv);
      rs = trig_scale(longint'(radius_minor), sv);
      ring = longint'(radius_major) + rc;
      vec[0] = '{trig_scale(ring, cu), trig_scale(ring, su), rs};
      vec[1] = '{-trig_scale(ring, su), trig_scale(ring, cu), 0};
      vec[2] = '{-trig_scale(rs, cu), -trig_scale(rs, su), rc};
      vec[3] = '{-trig_scale(ring, cu), -trig_scale(ring, su), 0};
      vec[4] = '{-trig_scale(rc, cu), -trig_scale(rc, su), -rs};
      vec[5] = '{trig_scale(rs, su), -trig_scale(rs, cu), 0};
      count = (item.derivative_order == tpd_pkg::ORDER_POINT) ? 1 :
              (item.derivative_order == tpd_pkg::ORDER_GRAD) ? 3 : 6;
      for (int k = 0; k < count; k++) begin
         longint comp [3];
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
               acc += longint'($signed(rot_row[i][16*j +: 16])) * vec[k][j];
            r = round_shift(acc, 14);
            if (k == 0) r += shift_xyz[i];
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            comp[i] = r;
         end
         exp_vec.vector_kind = kinds[k];
         exp_vec.coord_x = 32'(comp[0]);
         exp_vec.coord_y = 32'(comp[1]);
         exp_vec.coord_z = 32'(comp[2]);
         exp_vec.last_of_run = (k == count - 1);
         expected_vectors.push_back(exp_vec);
      end
   endtask

   // driver: one beat per start && !busy, random idle bursts after a beat
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else if (!(start && busy)) begin
         if (start) queue_torus_vectors(req_data);
         if (idle_left > 0) begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            start <= 1'b1;
            if (gaps_on && $urandom_range(0, 4) == 0) idle_left <= $urandom_range(1, 13);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe beat must match the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_vectors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: %p", rsp_data);
         end else begin
            tpd_pkg::tpd_rsp_type want;
            want = expected_vectors.pop_front();
            if (rsp_data.vector_kind !== want.vector_kind ||
                rsp_data.coord_x !== want.coord_x || rsp_data.coord_y !== want.coord_y ||
                rsp_data.coord_z !== want.coord_z ||
                rsp_data.last_of_run !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         tpd_pkg::REG_MAJOR: radius_major = val[31:0];
         tpd_pkg::REG_MINOR: radius_minor = val[31:0];
         tpd_pkg::REG_ROW_X: rot_row[0] = val;
         tpd_pkg::REG_ROW_Y: rot_row[1] = val;
         tpd_pkg::REG_ROW_Z: rot_row[2] = val;
         tpd_pkg::REG_OFFSET_X: shift_xyz[0] = longint'($signed(val[31:0]));
         tpd_pkg::REG_OFFSET_Y: shift_xyz[1] = longint'($signed(val[31:0]));
         default: shift_xyz[2] = longint'($signed(val[31:0]));
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_config(input logic [31:0] maj, input logic [31:0] mnr,
                              input logic [47:0] rx, input logic [47:0] ry,
                              input logic [47:0] rz, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] oz);
      // upper bits of the 32 bit registers carry junk, the block drops them
      write_reg(tpd_pkg::REG_MAJOR, {16'($urandom), maj});
      write_reg(tpd_pkg::REG_MINOR, {16'($urandom), mnr});
      write_reg(tpd_pkg::REG_ROW_X, rx);
      write_reg(tpd_pkg::REG_ROW_Y, ry);
      write_reg(tpd_pkg::REG_ROW_Z, rz);
      write_reg(tpd_pkg::REG_OFFSET_X, {16'($urandom), ox});
      write_reg(tpd_pkg::REG_OFFSET_Y, {16'($urandom), oy});
      write_reg(tpd_pkg::REG_OFFSET_Z, {16'($urandom), oz});
   endtask

   task automatic push_random_items(input int n);
      tpd_pkg::tpd_req_type item;
      for (int i = 0; i < n; i++) begin
         item.angle_u = tpd_pkg::ANGLE_BITS'($urandom);
         item.angle_v = tpd_pkg::ANGLE_BITS'($urandom);
         item.derivative_order = 2'($urandom_range(0, 3));
         pending_items.push_back(item);
      end
   endtask

   // wait until every beat is driven and every vector is back
   task automatic drain;
      do @(negedge clock);
      while (pending_items.size() != 0 || start || idle_left != 0 ||
             expected_vectors.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [47:0] random_row();
      return {16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   initial begin
      logic [tpd_pkg::ANGLE_BITS-1:0] corners [6];
      tpd_pkg::tpd_req_type item;
      cycles = 0;
      mismatches = 0;
      gaps_on = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      // reset values of the registers
      radius_major = 65536;
      radius_minor = 32768;
      rot_row = '{48'd16384, 48'd16384 << 16, 48'd16384 << 32};
      shift_xyz = '{0, 0, 0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: quadrant edges and full scale angles, every order incl. 3
      corners = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF};
      for (int i = 0; i < 6; i++) begin
         item.angle_u = corners[i];
         item.angle_v = corners[5 - i];
         item.derivative_order = 2'(i % 4);
         pending_items.push_back(item);
         item.angle_u = corners[(i + 2) % 6];
         item.angle_v = corners[i];
         item.derivative_order = 2'((i + 2) % 4);
         pending_items.push_back(item);
      end
      drain();

      // extremes: huge radii, -2.0 entries, offsets at full scale -> saturation
      load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, {16'h8000, 16'h8000, 16'h8000},
                  {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h0000},
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      for (int i = 0; i < 6; i++) begin
         item.angle_u = corners[i];
         item.angle_v = corners[(i + 3) % 6];
         item.derivative_order = 2'd3;
         pending_items.push_back(item);
      end
      push_random_items(30);
      drain();

      // zero radii and zero matrix
      load_config(32'd0, 32'd0, 48'd0, 48'd0, 48'd0, 32'd0, 32'd0, 32'h8000_0000);
      push_random_items(10);
      drain();

      // random settings, radii mostly moderate
      for (int p = 0; p < 4; p++) begin
         if (p == 3) gaps_on = 1'b0;   // final stretch back to back
         load_config(32'($urandom_range(0, 32'h00FF_FFFF)), 32'($urandom_range(0, 32'h007F_FFFF)),
                     random_row(), random_row(), random_row(),
                     32'($urandom), 32'($urandom), 32'($urandom));
         push_random_items(38);
         drain();
      end

      if (mismatches == 0 && expected_vectors.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
